FILE: design/uartq_pkg.sv
// package for the uart byte queues: widths, codes, states and control types
package uartq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;

    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int FLAG_W = 4;

    localparam logic [MODE_W-1:0] MODE_RX_CHAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SW_WRITE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TX_READY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SW_READ  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERR_READ = 3'd4;

    localparam logic [FLAG_W-1:0] ERR_OVERRUN = 4'b0001;
    localparam logic [FLAG_W-1:0] ERR_FRAMING = 4'b0010;
    localparam logic [FLAG_W-1:0] ERR_PARITY  = 4'b0100;
    localparam logic [FLAG_W-1:0] ERR_FULL    = 4'b1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } ctrl_cmd_t;

endpackage

FILE: design/uartq_req_if.sv
// request channel interface: one queue event per item
interface uartq_req_if;
    logic                          valid;
    logic                          ready;
    logic [uartq_pkg::MODE_W-1:0]  mode;
    logic [uartq_pkg::BYTE_W-1:0]  data_byte;
    logic                          frame_error;
    logic                          parity_fault;
    logic                          overrun;

    modport source (
        output valid, mode, data_byte, frame_error, parity_fault, overrun,
        input  ready
    );
    modport sink (
        input  valid, mode, data_byte, frame_error, parity_fault, overrun,
        output ready
    );
endinterface

FILE: design/uartq_rsp_if.sv
// response channel interface: one result per item
interface uartq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [uartq_pkg::BYTE_W-1:0]  out_byte;
    logic                          out_valid;
    logic                          accepted;
    logic [uartq_pkg::FLAG_W-1:0]  error_flags;

    modport source (
        output valid, out_byte, out_valid, accepted, error_flags,
        input  ready
    );
    modport sink (
        input  valid, out_byte, out_valid, accepted, error_flags,
        output ready
    );
endinterface

FILE: design/uartq_ctrl.sv
// controller state machine: sequences capture, execute and result load
module uartq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output uartq_pkg::ctrl_cmd_t cmd
);

    uartq_pkg::state_t state_reg;
    uartq_pkg::state_t state_next;
    logic              out_full_reg;
    logic              out_full_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= uartq_pkg::ST_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        out_full_next = out_full_reg && !out_ready;
        case (state_reg)
            uartq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = uartq_pkg::ST_EXEC;
                end
            end
            uartq_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = uartq_pkg::ST_LOAD;
            end
            uartq_pkg::ST_LOAD:
            begin
                if (!out_full_reg || out_ready)
                begin
                    cmd.load      = 1'b1;
                    out_full_next = 1'b1;
                    state_next    = uartq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uartq_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_full_reg;

    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == uartq_pkg::ST_EXEC)
        else $error("capture not followed by execute");

    a_exec_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == uartq_pkg::ST_EXEC |=> state_reg == uartq_pkg::ST_LOAD)
        else $error("execute not followed by load");

    a_load_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_full_reg)
        else $error("result load lost");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_full_reg || out_ready))
        else $error("result overwritten before taken");

endmodule

FILE: design/uartq_datapath.sv
// datapath: both byte queues, their indices, sticky flags and result registers
module uartq_datapath #(
    parameter int QUEUE_DEPTH = uartq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  uartq_pkg::ctrl_cmd_t          cmd,
    input  logic [uartq_pkg::MODE_W-1:0]  mode,
    input  logic [uartq_pkg::BYTE_W-1:0]  data_byte,
    input  logic                          frame_error,
    input  logic                          parity_fault,
    input  logic                          overrun,
    output logic [uartq_pkg::BYTE_W-1:0]  out_byte,
    output logic                          out_valid,
    output logic                          accepted,
    output logic [uartq_pkg::FLAG_W-1:0]  error_flags
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_LAST)
            res = '0;
        else
            res = idx + 1'b1;
        return res;
    endfunction

    logic [uartq_pkg::MODE_W-1:0] mode_reg;
    logic [uartq_pkg::BYTE_W-1:0] data_reg;
    logic                         fe_reg;
    logic                         pe_reg;
    logic                         ov_reg;

    logic [uartq_pkg::BYTE_W-1:0] rx_mem [QUEUE_DEPTH];
    logic [uartq_pkg::BYTE_W-1:0] tx_mem [QUEUE_DEPTH];
    logic [uartq_pkg::BYTE_W-1:0] rx_rdata_reg;
    logic [uartq_pkg::BYTE_W-1:0] tx_rdata_reg;

    logic [IDX_W-1:0] rx_wr_reg, rx_wr_next;
    logic [IDX_W-1:0] rx_rd_reg, rx_rd_next;
    logic [IDX_W-1:0] tx_wr_reg, tx_wr_next;
    logic [IDX_W-1:0] tx_rd_reg, tx_rd_next;
    logic [uartq_pkg::FLAG_W-1:0] sticky_reg, sticky_next;

    logic                         st_valid_reg, st_valid_next;
    logic                         st_acc_reg, st_acc_next;
    logic                         st_from_tx_reg, st_from_tx_next;
    logic [uartq_pkg::FLAG_W-1:0] st_flags_reg, st_flags_next;

    logic [uartq_pkg::BYTE_W-1:0] out_byte_reg;
    logic                         out_valid_reg;
    logic                         accepted_reg;
    logic [uartq_pkg::FLAG_W-1:0] error_flags_reg;

    logic                         rx_we;
    logic                         tx_we;
    logic                         rx_full;
    logic                         tx_full;
    logic                         rx_empty;
    logic                         tx_empty;
    logic [uartq_pkg::BYTE_W-1:0] byte_sel;

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            data_reg <= data_byte;
            fe_reg   <= frame_error;
            pe_reg   <= parity_fault;
            ov_reg   <= overrun;
        end
    end

    assign rx_full  = advance(rx_wr_reg) == rx_rd_reg;
    assign tx_full  = advance(tx_wr_reg) == tx_rd_reg;
    assign rx_empty = rx_rd_reg == rx_wr_reg;
    assign tx_empty = tx_rd_reg == tx_wr_reg;

    always_comb
    begin
        rx_wr_next      = rx_wr_reg;
        rx_rd_next      = rx_rd_reg;
        tx_wr_next      = tx_wr_reg;
        tx_rd_next      = tx_rd_reg;
        sticky_next     = sticky_reg;
        st_valid_next   = st_valid_reg;
        st_acc_next     = st_acc_reg;
        st_from_tx_next = st_from_tx_reg;
        st_flags_next   = st_flags_reg;
        rx_we           = 1'b0;
        tx_we           = 1'b0;
        if (cmd.exec)
        begin
            st_valid_next   = 1'b0;
            st_acc_next     = 1'b0;
            st_from_tx_next = 1'b0;
            st_flags_next   = '0;
            case (mode_reg)
                uartq_pkg::MODE_RX_CHAR:
                begin
                    if (ov_reg)
                        sticky_next = sticky_next | uartq_pkg::ERR_OVERRUN;
                    if (fe_reg)
                        sticky_next = sticky_next | uartq_pkg::ERR_FRAMING;
                    else if (pe_reg)
                        sticky_next = sticky_next | uartq_pkg::ERR_PARITY;
                    else if (!rx_full)
                    begin
                        rx_we       = 1'b1;
                        rx_wr_next  = advance(rx_wr_reg);
                        st_acc_next = 1'b1;
                    end
                    else
                        sticky_next = sticky_next | uartq_pkg::ERR_FULL;
                end
                uartq_pkg::MODE_SW_WRITE:
                begin
                    if (!tx_full)
                    begin
                        tx_we       = 1'b1;
                        tx_wr_next  = advance(tx_wr_reg);
                        st_acc_next = 1'b1;
                    end
                end
                uartq_pkg::MODE_TX_READY:
                begin
                    st_from_tx_next = 1'b1;
                    if (!tx_empty)
                    begin
                        tx_rd_next    = advance(tx_rd_reg);
                        st_valid_next = 1'b1;
                    end
                end
                uartq_pkg::MODE_SW_READ:
                begin
                    if (!rx_empty)
                    begin
                        rx_rd_next    = advance(rx_rd_reg);
                        st_valid_next = 1'b1;
                    end
                end
                uartq_pkg::MODE_ERR_READ:
                begin
                    st_flags_next = sticky_reg;
                    sticky_next   = '0;
                end
                default:
                begin
                    st_flags_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_reg      <= '0;
            rx_rd_reg      <= '0;
            tx_wr_reg      <= '0;
            tx_rd_reg      <= '0;
            sticky_reg     <= '0;
            st_valid_reg   <= 1'b0;
            st_acc_reg     <= 1'b0;
            st_from_tx_reg <= 1'b0;
            st_flags_reg   <= '0;
        end
        else
        begin
            rx_wr_reg      <= rx_wr_next;
            rx_rd_reg      <= rx_rd_next;
            tx_wr_reg      <= tx_wr_next;
            tx_rd_reg      <= tx_rd_next;
            sticky_reg     <= sticky_next;
            st_valid_reg   <= st_valid_next;
            st_acc_reg     <= st_acc_next;
            st_from_tx_reg <= st_from_tx_next;
            st_flags_reg   <= st_flags_next;
        end
    end

    // receive queue storage
    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_mem[rx_wr_reg] <= data_reg;
        if (cmd.exec)
            rx_rdata_reg <= rx_mem[rx_rd_reg];
    end

    // send queue storage
    always_ff @(posedge clk)
    begin
        if (tx_we)
            tx_mem[tx_wr_reg] <= data_reg;
        if (cmd.exec)
            tx_rdata_reg <= tx_mem[tx_rd_reg];
    end

    always_comb
    begin
        if (!st_valid_reg)
            byte_sel = '0;
        else if (st_from_tx_reg)
            byte_sel = tx_rdata_reg;
        else
            byte_sel = rx_rdata_reg;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_byte_reg    <= byte_sel;
            out_valid_reg   <= st_valid_reg;
            accepted_reg    <= st_acc_reg;
            error_flags_reg <= st_flags_reg;
        end
    end

    assign out_byte    = out_byte_reg;
    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign error_flags = error_flags_reg;

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_we && tx_we))
        else $error("both queues written by one item");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, rx_wr_reg} < (IDX_W + 1)'(QUEUE_DEPTH))
        && ({1'b0, rx_rd_reg} < (IDX_W + 1)'(QUEUE_DEPTH))
        && ({1'b0, tx_wr_reg} < (IDX_W + 1)'(QUEUE_DEPTH))
        && ({1'b0, tx_rd_reg} < (IDX_W + 1)'(QUEUE_DEPTH)))
        else $error("queue index out of range");

    a_pop_push_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_acc_reg && st_valid_reg))
        else $error("one item both stored and popped");

    a_err_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && mode_reg == uartq_pkg::MODE_ERR_READ) |=> sticky_reg == '0)
        else $error("error flags not cleared on read");

endmodule

FILE: design/uart_rx_tx_byte_queues_top.sv
// top level of the uart receive and send byte queues
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | mode, data_byte, frame_error, parity_fault, overrun
//  rsp     | out | valid / ready | out_byte, out_valid, accepted, error_flags
//
// an item passes through capture, execute with the queue memory read, and result load
// the read port of each queue memory is registered in execute, so the result is loaded in a later step
// req is ready again while a finished result still waits in the output register
// a result that finds the output register full waits in load until rsp is taken
// reset clears indices and flags; queue contents are undefined until written
module uart_rx_tx_byte_queues_top #(
    parameter int QUEUE_DEPTH = uartq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    uartq_req_if.sink   req,
    uartq_rsp_if.source rsp
);

    uartq_pkg::ctrl_cmd_t cmd;

    uartq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    uartq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (req.mode),
        .data_byte    (req.data_byte),
        .frame_error  (req.frame_error),
        .parity_fault (req.parity_fault),
        .overrun      (req.overrun),
        .out_byte     (rsp.out_byte),
        .out_valid    (rsp.out_valid),
        .accepted     (rsp.accepted),
        .error_flags  (rsp.error_flags)
    );

endmodule
